[rtl/lpms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpms_pkg
// Shared types and constants for the LED pattern mode sequencer.
// ----------------------------------------------------------------------------
package lpms_pkg;

	localparam int STEP_W = 24;
	localparam int MODE_W = 3;
	localparam logic [STEP_W-1:0] STEP_RESET = 24'd100000;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE  = 3'd0,
		MODE_ON    = 3'd1,
		MODE_BLINK = 3'd2,
		MODE_DOT   = 3'd3,
		MODE_FILL  = 3'd4,
		MODE_OFF   = 3'd5
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic              phase;
		logic              await_release;
		logic [STEP_W-1:0] tick_count;
	} ctrl_t;

endpackage

[rtl/lpms_next.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpms_next
// Next-state logic: mode sequencing, step timing and LED pattern update for
// one button sample.
// ----------------------------------------------------------------------------
module lpms_next import lpms_pkg::*; #(
	parameter int LED_COUNT = 10
) (
	input  ctrl_t                           ctrl_cur,
	input  logic [LED_COUNT-1:0]            pattern_cur,
	input  logic [$clog2(LED_COUNT)-1:0]    pos_cur,
	input  logic                            pressed,
	input  logic [STEP_W-1:0]               limit,
	output ctrl_t                           ctrl_nxt,
	output logic [LED_COUNT-1:0]            pattern_nxt,
	output logic [$clog2(LED_COUNT)-1:0]    pos_nxt
);

	localparam int POS_W = $clog2(LED_COUNT);
	localparam logic [POS_W-1:0] TOP = POS_W'(LED_COUNT - 1);
	localparam logic [LED_COUNT-1:0] ALL_ON = {LED_COUNT{1'b1}};
	localparam logic [LED_COUNT-1:0] BIT0 = LED_COUNT'(1);

	logic [STEP_W-1:0]    tick_inc;
	logic                 step_end;
	mode_t                mode_enter;
	logic [LED_COUNT-1:0] bit_pos;
	logic [LED_COUNT-1:0] bit_up;
	logic [LED_COUNT-1:0] bit_dn;

	assign tick_inc = (ctrl_cur.tick_count < limit) ? ctrl_cur.tick_count + 1'b1
		: ctrl_cur.tick_count;
	assign step_end = (tick_inc >= limit);
	assign bit_pos  = BIT0 << pos_cur;
	assign bit_up   = BIT0 << (pos_cur + 1'b1);
	assign bit_dn   = BIT0 << (pos_cur - 1'b1);

	always_comb begin
		case (ctrl_cur.mode)
			MODE_ON:    mode_enter = MODE_BLINK;
			MODE_BLINK: mode_enter = MODE_DOT;
			MODE_DOT:   mode_enter = MODE_FILL;
			MODE_FILL:  mode_enter = MODE_OFF;
			default:    mode_enter = MODE_ON;
		endcase
	end

	always_comb begin
		ctrl_nxt    = ctrl_cur;
		pattern_nxt = pattern_cur;
		pos_nxt     = pos_cur;
		if (ctrl_cur.await_release) begin
			if (!pressed) begin
				ctrl_nxt.await_release = 1'b0;
				ctrl_nxt.mode          = mode_enter;
				ctrl_nxt.tick_count    = '0;
				ctrl_nxt.phase         = 1'b0;
				pos_nxt                = '0;
				case (mode_enter)
					MODE_ON, MODE_BLINK: pattern_nxt = ALL_ON;
					MODE_DOT, MODE_FILL: pattern_nxt = BIT0;
					default:             pattern_nxt = '0;
				endcase
			end
		end else if (ctrl_cur.mode == MODE_IDLE || ctrl_cur.mode > MODE_OFF) begin
			ctrl_nxt.mode          = MODE_IDLE;
			pattern_nxt            = '0;
			ctrl_nxt.await_release = pressed;
		end else begin
			ctrl_nxt.tick_count = tick_inc;
			if (step_end) begin
				ctrl_nxt.tick_count = '0;
				if (pressed) begin
					ctrl_nxt.await_release = 1'b1;
					if (ctrl_cur.mode == MODE_DOT)
						pattern_nxt = '0;
				end else begin
					case (ctrl_cur.mode)
						MODE_ON:    pattern_nxt = ALL_ON;
						MODE_BLINK: pattern_nxt = ~pattern_cur;
						MODE_DOT: begin
							if (!ctrl_cur.phase) begin
								if (pos_cur < TOP) begin
									pos_nxt     = pos_cur + 1'b1;
									pattern_nxt = bit_up;
								end else begin
									ctrl_nxt.phase = 1'b1;
									pattern_nxt    = bit_pos;
								end
							end else begin
								if (pos_cur != '0) begin
									pos_nxt     = pos_cur - 1'b1;
									pattern_nxt = bit_dn;
								end else begin
									ctrl_nxt.phase = 1'b0;
									pattern_nxt    = bit_pos;
								end
							end
						end
						MODE_FILL: begin
							if (!ctrl_cur.phase) begin
								if (pos_cur < TOP) begin
									pos_nxt     = pos_cur + 1'b1;
									pattern_nxt = pattern_cur | bit_up;
								end else begin
									ctrl_nxt.phase = 1'b1;
									pattern_nxt    = pattern_cur & ~bit_pos;
								end
							end else begin
								if (pos_cur != '0) begin
									pos_nxt     = pos_cur - 1'b1;
									pattern_nxt = pattern_cur & ~bit_dn;
								end else begin
									ctrl_nxt.phase = 1'b0;
									pattern_nxt    = pattern_cur | bit_pos;
								end
							end
						end
						default: pattern_nxt = '0;
					endcase
				end
			end
		end
	end

endmodule

[rtl/led_pattern_mode_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pattern_mode_sequencer
// Push-button driven LED bar pattern sequencer.
// ----------------------------------------------------------------------------
// One pin sample is taken per cycle and yields one result (LED pattern and
// current mode); it passes an input register then the result register,
// and a new sample is taken every cycle while the output side keeps up.
// Each press-and-release steps through all-on, blink, bouncing dot,
// fill-then-empty and all-off; patterns advance every step_cycles samples
// (zero counts as one) and the button is checked at each step end.
module led_pattern_mode_sequencer import lpms_pkg::*; #(
	parameter int LED_COUNT = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 pin_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [LED_COUNT-1:0] leds,
	output logic [MODE_W-1:0]    mode,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [STEP_W-1:0]    step_cycles
);

	localparam int POS_W = $clog2(LED_COUNT);

	logic                 valid_s1;
	logic                 pin_s1;
	logic                 out_valid_q;
	logic [LED_COUNT-1:0] leds_q;
	logic [MODE_W-1:0]    mode_q;
	logic [STEP_W-1:0]    step_cycles_q;
	ctrl_t                ctrl_q;
	logic [LED_COUNT-1:0] pattern_q;
	logic [POS_W-1:0]     pos_q;

	ctrl_t                ctrl_nxt;
	logic [LED_COUNT-1:0] pattern_nxt;
	logic [POS_W-1:0]     pos_nxt;
	logic [STEP_W-1:0]    limit;
	logic                 out_ready;
	logic                 fire;

	assign cfg_ready = 1'b1;
	assign out_ready = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign limit     = (step_cycles_q == '0) ? STEP_W'(1) : step_cycles_q;

	assign out_valid = out_valid_q;
	assign leds      = leds_q;
	assign mode      = mode_q;

	lpms_next #(
		.LED_COUNT(LED_COUNT)
	) u_next (
		.ctrl_cur    (ctrl_q),
		.pattern_cur (pattern_q),
		.pos_cur     (pos_q),
		.pressed     (!pin_s1),
		.limit       (limit),
		.ctrl_nxt    (ctrl_nxt),
		.pattern_nxt (pattern_nxt),
		.pos_nxt     (pos_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cycles_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_cycles_q <= step_cycles;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			pin_s1 <= pin_level;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q    <= '{mode: MODE_IDLE, phase: 1'b0, await_release: 1'b0,
				tick_count: '0};
			pattern_q <= '0;
			pos_q     <= '0;
		end else if (fire) begin
			ctrl_q    <= ctrl_nxt;
			pattern_q <= pattern_nxt;
			pos_q     <= pos_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			leds_q <= pattern_nxt;
			mode_q <= ctrl_nxt.mode;
		end
	end

endmodule
